// File: src/tkss_pkg.sv
// Shared types and constants of the top-k similarity selector.
package tkss_pkg;

    localparam int DEF_MAX_KEEP   = 16;
    localparam int DEF_ID_BITS    = 16;
    localparam int DEF_SCORE_BITS = 16;

    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUERY_BITS    = 16;
    localparam int KEEP_BITS     = 5;
    localparam int RANK_BITS     = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_ID   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_COUNT = CFG_IDX_BITS'(1);

    localparam logic [KEEP_BITS-1:0] KEEP_COUNT_RESET = KEEP_BITS'(10);

    typedef struct packed {
        logic insert;
        logic shift_out;
        logic clear;
    } t_cell_ctl;

endpackage

// File: src/tkss_cell.sv
// One cell of the sorted insertion chain: holds one ranked entry.
module tkss_cell #(
    parameter int ID_BITS    = tkss_pkg::DEF_ID_BITS,
    parameter int SCORE_BITS = tkss_pkg::DEF_SCORE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tkss_pkg::t_cell_ctl          i_ctl,
    input  logic        [ID_BITS-1:0]    i_new_id,
    input  logic signed [SCORE_BITS-1:0] i_new_score,
    input  logic        [ID_BITS-1:0]    i_prev_id,
    input  logic signed [SCORE_BITS-1:0] i_prev_score,
    input  logic                         i_prev_valid,
    input  logic                         i_prev_take,
    input  logic        [ID_BITS-1:0]    i_next_id,
    input  logic signed [SCORE_BITS-1:0] i_next_score,
    input  logic                         i_next_valid,
    output logic        [ID_BITS-1:0]    o_id,
    output logic signed [SCORE_BITS-1:0] o_score,
    output logic                         o_valid,
    output logic                         o_take
);
    import tkss_pkg::*;

    logic        [ID_BITS-1:0]    r_id;
    logic signed [SCORE_BITS-1:0] r_score;
    logic                         r_valid;
    logic        [ID_BITS-1:0]    n_id;
    logic signed [SCORE_BITS-1:0] n_score;
    logic                         n_valid;

    assign o_take = !r_valid || (i_new_score > r_score);

    always_comb begin
        n_id    = r_id;
        n_score = r_score;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift_out) begin
            n_id    = i_next_id;
            n_score = i_next_score;
            n_valid = i_next_valid;
        end else if (i_ctl.insert) begin
            if (i_prev_take) begin
                n_id    = i_prev_id;
                n_score = i_prev_score;
                n_valid = i_prev_valid;
            end else if (o_take) begin
                n_id    = i_new_id;
                n_score = i_new_score;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_score <= n_score;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_id    = r_id;
    assign o_score = r_score;
    assign o_valid = r_valid;

endmodule

// File: src/top_k_similarity_selector_unit.sv
// Top level of the top-k similarity selector: config, chain of cells, drain control.
// Takes one candidate per cycle while busy is low; each whose ID differs from the query ID is
// inserted into a sorted chain of MAX_KEEP cells in the cycle it is accepted. After a candidate
// marked last, busy stays high while the chain shifts its entries out through cell 0, one
// neighbour per cycle. Results appear, registered, on o_result_valid in the cycle after each
// drain step, for a single cycle each, and cannot be held off; a pass with nothing kept emits none.
module top_k_similarity_selector_unit #(
    parameter int MAX_KEEP   = tkss_pkg::DEF_MAX_KEEP,
    parameter int ID_BITS    = tkss_pkg::DEF_ID_BITS,
    parameter int SCORE_BITS = tkss_pkg::DEF_SCORE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tkss_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [tkss_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [ID_BITS-1:0]             i_candidate_id,
    input  logic signed [SCORE_BITS-1:0]          i_score,
    input  logic                                  i_last_candidate,
    output logic                                  o_result_valid,
    output logic        [tkss_pkg::RANK_BITS-1:0] o_rank,
    output logic        [ID_BITS-1:0]             o_neighbor_id,
    output logic signed [SCORE_BITS-1:0]          o_neighbor_score,
    output logic                                  o_end_of_list
);
    import tkss_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEEP + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                    r_state;
    logic                    n_state;
    logic [QUERY_BITS-1:0]   r_query_id;
    logic [KEEP_BITS-1:0]    r_keep_count;
    logic [CNT_W-1:0]        r_limit;
    logic [CNT_W-1:0]        n_limit;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;

    logic                    r_out_valid;
    logic [RANK_BITS-1:0]    r_rank;
    logic [ID_BITS-1:0]      r_out_id;
    logic [SCORE_BITS-1:0]   r_out_score;
    logic                    r_out_end;

    logic                    w_accept;
    logic [ID_BITS-1:0]      w_query;
    logic [31:0]             w_keep32;
    logic [31:0]             w_cnt32;
    logic                    w_emit;
    logic                    w_end;
    t_cell_ctl               w_ctl;

    logic        [ID_BITS-1:0]    w_id    [0:MAX_KEEP];
    logic signed [SCORE_BITS-1:0] w_sc    [0:MAX_KEEP];
    logic                         w_valid [0:MAX_KEEP];
    logic                         w_take  [0:MAX_KEEP-1];

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;
    assign w_query     = ID_BITS'(32'(r_query_id));
    assign w_keep32    = 32'(r_keep_count);
    assign w_cnt32     = 32'(r_cnt);

    assign w_id[MAX_KEEP]    = '0;
    assign w_sc[MAX_KEEP]    = '0;
    assign w_valid[MAX_KEEP] = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id   <= '0;
            r_keep_count <= KEEP_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_QUERY_ID:   r_query_id   <= i_cfg_data;
                REG_KEEP_COUNT: r_keep_count <= i_cfg_data[KEEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_emit = (r_state == ST_DRAIN) && w_valid[0];
    assign w_end  = !w_valid[1] || (w_cnt32 + 32'd1 == 32'(r_limit));

    always_comb begin
        n_state         = r_state;
        n_limit         = r_limit;
        n_cnt           = r_cnt;
        w_ctl.insert    = 1'b0;
        w_ctl.shift_out = 1'b0;
        w_ctl.clear     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctl.insert = (i_candidate_id != w_query);
                    if (i_last_candidate) begin
                        n_state = ST_DRAIN;
                        n_cnt   = '0;
                        if (w_keep32 == 32'd0) begin
                            n_limit = CNT_W'(1);
                        end else if (w_keep32 > 32'(MAX_KEEP)) begin
                            n_limit = CNT_W'(MAX_KEEP);
                        end else begin
                            n_limit = CNT_W'(w_keep32);
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (w_emit && !w_end) begin
                    w_ctl.shift_out = 1'b1;
                    n_cnt           = CNT_W'(w_cnt32 + 32'd1);
                end else begin
                    w_ctl.clear = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_limit     <= n_limit;
        r_cnt       <= n_cnt;
        r_rank      <= RANK_BITS'(w_cnt32);
        r_out_id    <= w_id[0];
        r_out_score <= w_sc[0];
        r_out_end   <= w_end;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_emit;
        end
    end

    for (genvar k = 0; k < MAX_KEEP; k++) begin : g_cell
        logic        [ID_BITS-1:0]    w_pid;
        logic signed [SCORE_BITS-1:0] w_psc;
        logic                         w_pvalid;
        logic                         w_ptake;
        if (k == 0) begin : g_head
            assign w_pid    = '0;
            assign w_psc    = '0;
            assign w_pvalid = 1'b0;
            assign w_ptake  = 1'b0;
        end else begin : g_body
            assign w_pid    = w_id[k-1];
            assign w_psc    = w_sc[k-1];
            assign w_pvalid = w_valid[k-1];
            assign w_ptake  = w_take[k-1];
        end
        tkss_cell #(
            .ID_BITS    (ID_BITS),
            .SCORE_BITS (SCORE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_id     (i_candidate_id),
            .i_new_score  (i_score),
            .i_prev_id    (w_pid),
            .i_prev_score (w_psc),
            .i_prev_valid (w_pvalid),
            .i_prev_take  (w_ptake),
            .i_next_id    (w_id[k+1]),
            .i_next_score (w_sc[k+1]),
            .i_next_valid (w_valid[k+1]),
            .o_id         (w_id[k]),
            .o_score      (w_sc[k]),
            .o_valid      (w_valid[k]),
            .o_take       (w_take[k])
        );
    end

    assign o_result_valid   = r_out_valid;
    assign o_rank           = r_rank;
    assign o_neighbor_id    = r_out_id;
    assign o_neighbor_score = r_out_score;
    assign o_end_of_list    = r_out_end;

    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_candidate) |=> busy)
        else $error("last item did not start a drain");

    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_DRAIN))
        else $error("result outside a drain");

    a_gap_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_end_of_list) |=> !o_result_valid)
        else $error("result after end of list");

    a_no_insert_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_ctl.insert)
        else $error("insert during drain");

endmodule
